// ----- hdl/bba_pkg.sv -----
package bba_pkg;

    // bitmap geometry
    localparam int MAP_BITS_DEFAULT = 512;
    localparam int INDEX_SPAN       = 512;
    localparam int INDEX_W          = 9;
    localparam int LIM_W            = 10;
    localparam int WORD_BITS        = 32;
    localparam int WORD_IDX_W       = $clog2(WORD_BITS);

    // register reset value
    localparam logic [LIM_W-1:0] BITS_IN_USE_RESET = LIM_W'(500);

    // request kinds
    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    // result codes
    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_DOUBLE = 2'd2,
        STATUS_RANGE  = 2'd3
    } status_t;

    // lowest free bit search result
    typedef struct packed {
        logic                  hit;
        logic [WORD_IDX_W-1:0] pos;
    } find_result_t;

endpackage

// ----- hdl/bba_ram.sv -----
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/bba_find.sv -----
module bba_find
    import bba_pkg::*;
(
    input  logic [WORD_BITS-1:0] avail,
    output find_result_t         result
);

    // priority pick of the lowest available bit
    always_comb
    begin
        result.hit = 1'b0;
        result.pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (avail[b])
            begin
                result.hit = 1'b1;
                result.pos = WORD_IDX_W'(b);
            end
        end
    end

endmodule

// ----- hdl/block_bitmap_allocator.sv -----
// First-fit bitmap allocator; bitmap kept in 32-bit words of one synchronous RAM.
// Steps: a free reads its word, then checks its bit; an allocate reads words from
// word 0 up, k words (k up to ceil(limit/32)); an out of range free or a zero limit
// goes straight to the output step. A new request waits until the result is loaded.
// Rate is set by the single RAM read port scanning one bitmap word per cycle.
// Reset clears the map through per-word valid bits and loads bits_in_use with 500.
module block_bitmap_allocator
    import bba_pkg::*;
#(
    parameter int MAP_BITS = MAP_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic [INDEX_W-1:0] free_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [INDEX_W-1:0] granted_index,
    output logic [1:0]         status,
    input  logic               cfg_we,
    input  logic [LIM_W-1:0]   cfg_wdata
);

    localparam int USED_BITS = (MAP_BITS < INDEX_SPAN) ? MAP_BITS : INDEX_SPAN;
    localparam int DEPTH     = (USED_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_PUT
    } state_t;

    state_t               state_reg, state_next;
    logic                 kind_reg, kind_next;
    logic [INDEX_W-1:0]   idx_reg, idx_next;
    logic [LIM_W-1:0]     lim_reg, lim_next;
    logic [ADDR_W-1:0]    word_reg, word_next;
    logic [ADDR_W-1:0]    last_reg, last_next;
    logic [INDEX_W-1:0]   res_index_reg, res_index_next;
    status_t              res_status_reg, res_status_next;
    logic                 out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]   granted_reg, granted_next;
    status_t              status_reg, status_next;
    logic [DEPTH-1:0]     wvalid_reg, wvalid_next;
    logic [LIM_W-1:0]     bits_in_use_reg, bits_in_use_next;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic [LIM_W-1:0]     lim;
    logic [WORD_BITS-1:0] word_data;
    logic [WORD_BITS-1:0] avail;
    logic [LIM_W-1:0]     word_base;
    find_result_t         find;

    // bitmap word store
    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_map (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // usable limit, saturated to the map size
    assign lim = (bits_in_use_reg > LIM_W'(USED_BITS)) ? LIM_W'(USED_BITS) : bits_in_use_reg;

    // a word never written since reset reads as all free
    assign word_data = wvalid_reg[word_reg] ? ram_rdata : '0;
    assign word_base = LIM_W'(word_reg) << WORD_IDX_W;

    // free bits below the limit in the current word
    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            avail[b] = !word_data[b] && ((word_base | LIM_W'(b)) < lim_reg);
        end
    end

    bba_find u_find (
        .avail (avail),
        .result(find)
    );

    // sequencer next state
    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        idx_next         = idx_reg;
        lim_next         = lim_reg;
        word_next        = word_reg;
        last_next        = last_reg;
        res_index_next   = res_index_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg && out_stall;
        granted_next     = granted_reg;
        status_next      = status_reg;
        wvalid_next      = wvalid_reg;
        bits_in_use_next = bits_in_use_reg;
        ram_we           = 1'b0;
        ram_waddr        = word_reg;
        ram_wdata        = word_data;
        ram_re           = 1'b0;
        ram_raddr        = word_reg;

        if (cfg_we)
        begin
            bits_in_use_next = cfg_wdata;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next      = kind;
                    idx_next       = free_index;
                    lim_next       = lim;
                    res_index_next = '0;
                    if (kind == KIND_FREE)
                    begin
                        if (LIM_W'(free_index) >= lim)
                        begin
                            res_status_next = STATUS_RANGE;
                            state_next      = S_PUT;
                        end
                        else
                        begin
                            word_next  = ADDR_W'(free_index >> WORD_IDX_W);
                            ram_re     = 1'b1;
                            ram_raddr  = ADDR_W'(free_index >> WORD_IDX_W);
                            state_next = S_EVAL;
                        end
                    end
                    else
                    begin
                        if (lim == '0)
                        begin
                            res_status_next = STATUS_FULL;
                            state_next      = S_PUT;
                        end
                        else
                        begin
                            word_next  = '0;
                            last_next  = ADDR_W'((lim - LIM_W'(1)) >> WORD_IDX_W);
                            ram_re     = 1'b1;
                            ram_raddr  = '0;
                            state_next = S_EVAL;
                        end
                    end
                end
            end

            S_EVAL:
            begin
                if (kind_reg == KIND_FREE)
                begin
                    if (!word_data[idx_reg[WORD_IDX_W-1:0]])
                    begin
                        res_status_next = STATUS_DOUBLE;
                    end
                    else
                    begin
                        ram_we          = 1'b1;
                        ram_wdata       = word_data
                                          & ~(WORD_BITS'(1) << idx_reg[WORD_IDX_W-1:0]);
                        res_status_next = STATUS_OK;
                    end
                    state_next = S_PUT;
                end
                else if (find.hit)
                begin
                    ram_we          = 1'b1;
                    ram_wdata       = word_data | (WORD_BITS'(1) << find.pos);
                    res_index_next  = INDEX_W'({word_reg, find.pos});
                    res_status_next = STATUS_OK;
                    state_next      = S_PUT;
                end
                else if (word_reg == last_reg)
                begin
                    res_status_next = STATUS_FULL;
                    state_next      = S_PUT;
                end
                else
                begin
                    word_next = word_reg + ADDR_W'(1);
                    ram_re    = 1'b1;
                    ram_raddr = word_reg + ADDR_W'(1);
                end
                if (ram_we)
                begin
                    wvalid_next[word_reg] = 1'b1;
                end
            end

            S_PUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    granted_next   = res_index_reg;
                    status_next    = res_status_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            kind_reg        <= 1'b0;
            idx_reg         <= '0;
            lim_reg         <= '0;
            word_reg        <= '0;
            last_reg        <= '0;
            res_index_reg   <= '0;
            res_status_reg  <= STATUS_OK;
            out_valid_reg   <= 1'b0;
            granted_reg     <= '0;
            status_reg      <= STATUS_OK;
            wvalid_reg      <= '0;
            bits_in_use_reg <= BITS_IN_USE_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            kind_reg        <= kind_next;
            idx_reg         <= idx_next;
            lim_reg         <= lim_next;
            word_reg        <= word_next;
            last_reg        <= last_next;
            res_index_reg   <= res_index_next;
            res_status_reg  <= res_status_next;
            out_valid_reg   <= out_valid_next;
            granted_reg     <= granted_next;
            status_reg      <= status_next;
            wvalid_reg      <= wvalid_next;
            bits_in_use_reg <= bits_in_use_next;
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign granted_index = granted_reg;
    assign status        = status_reg;

    // map writes come only from the evaluate step
    a_write_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_EVAL))
        else $error("bitmap write outside evaluate step");

    // an accepted word starts work
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("accepted word did not start");

    // only a successful allocate grants a nonzero index
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STATUS_OK)) |-> (granted_index == '0))
        else $error("failed request carries an index");

    // the scan never passes the last word below the limit
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EVAL) && (kind_reg == KIND_ALLOC)) |-> (word_reg <= last_reg))
        else $error("scan ran past the limit");

endmodule
